[hw/rtl/pdhd_pkg.sv]
// Package for the PD heading/distance drive controller.
// Request codes, register indexes, fixed arithmetic widths and limits.
// No dependencies.
package pdhd_pkg;

  typedef enum logic [2:0] {
    REQ_TURN       = 3'd0,
    REQ_HEAD_DRIVE = 3'd1,
    REQ_HEAD_LIM   = 3'd2,
    REQ_DIST       = 3'd3,
    REQ_DIST_HEAD  = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    CFG_TURN_KP      = 3'd0,
    CFG_TURN_KD      = 3'd1,
    CFG_DRIVE_KP     = 3'd2,
    CFG_DRIVE_KD     = 3'd3,
    CFG_CRUISE_SPEED = 3'd4,
    CFG_HEAD_TOL     = 3'd5,
    CFG_DIST_TOL     = 3'd6
  } cfg_idx_e;

  localparam int GAIN_W     = 31;
  localparam int Q15_W      = 16;
  localparam int TOL_W      = 16;
  localparam int MAXT_W     = 15;
  localparam int LIM_W      = 17;
  localparam int BASE_W     = 18;
  localparam int PROD_EXT_W = 66;
  localparam int TERM_W     = 63;
  localparam int SUM_W      = 64;
  localparam int RND_SHIFT  = 9;
  localparam int CORR_W     = SUM_W - RND_SHIFT;
  localparam int MIX_W      = CORR_W + 2;

  localparam logic [PROD_EXT_W-1:0] PROD_LIM = PROD_EXT_W'(1) << 61;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(256);
  localparam logic signed [MIX_W-1:0] Q15_MAX = MIX_W'(32767);
  localparam logic signed [MIX_W-1:0] Q15_MIN = -MIX_W'(32768);

  localparam int HEAD_TOL = 256;
  localparam int DIST_TOL = 1024;

  localparam logic [GAIN_W-1:0] GAIN_RST     = '0;
  localparam logic [TOL_W-1:0]  HEAD_TOL_RST = 16'd128;
  localparam logic [TOL_W-1:0]  DIST_TOL_RST = 16'd256;

endpackage

[hw/rtl/pd_heading_distance_drive_controller_core.sv]
// PD heading/distance drive controller, top level.
// Seven-stage pipeline: errors, magnitudes, products, saturate, round, mode select, drive mix.
// Depends on pdhd_pkg.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | req_type, headings, distances, speed,
//          |           |                          | max_turn
//  out     | source    | out_valid_o / out_stall_i | left_drive, right_drive, done_res
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction per cycle while out_stall_i is low; after acceptance the result passes
// through the 31-bit gain multipliers and saturating round stages to the output register.
// Stored errors update at acceptance, so back-to-back ticks see the prior error.
// Reset clears gains, cruise speed, stored errors and all stage valids;
// tolerances reset to 128 and 256.
// out_stall_i backs up the pipeline stage by stage; in_stall_o rises only when full.
module pd_heading_distance_drive_controller_core
  import pdhd_pkg::*;
#(
  parameter int HEADING_WIDTH  = 20,
  parameter int DISTANCE_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       req_type_i,
  input  logic signed [HEADING_WIDTH-1:0]  target_heading_i,
  input  logic signed [HEADING_WIDTH-1:0]  measured_heading_i,
  input  logic signed [DISTANCE_WIDTH-1:0] target_distance_i,
  input  logic signed [DISTANCE_WIDTH-1:0] measured_distance_i,
  input  logic signed [Q15_W-1:0]          speed_i,
  input  logic [MAXT_W-1:0]                max_turn_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [Q15_W-1:0]          left_drive_o,
  output logic signed [Q15_W-1:0]          right_drive_o,
  output logic                             done_res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [2:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  localparam int HEW  = HEADING_WIDTH + 1;
  localparam int HDW  = HEADING_WIDTH + 2;
  localparam int DEW  = DISTANCE_WIDTH + 1;
  localparam int DDW  = DISTANCE_WIDTH + 2;
  localparam int HEPW = GAIN_W + HEW;
  localparam int HDPW = GAIN_W + HDW;
  localparam int DEPW = GAIN_W + DEW;
  localparam int DDPW = GAIN_W + DDW;
  localparam int HTCW = (HDW > TOL_W) ? HDW : TOL_W;
  localparam int DTCW = (DDW > TOL_W) ? DDW : TOL_W;

  function automatic logic signed [TERM_W-1:0] sign_sat(
    input logic [PROD_EXT_W-1:0] p,
    input logic                  neg
  );
    logic [PROD_EXT_W-1:0] m;
    m = (p > PROD_LIM) ? PROD_LIM : p;
    return neg ? -TERM_W'(m) : TERM_W'(m);
  endfunction

  function automatic logic signed [CORR_W-1:0] clamp(
    input logic signed [CORR_W-1:0] x,
    input logic signed [LIM_W-1:0]  lim
  );
    logic signed [CORR_W-1:0] hi;
    logic signed [CORR_W-1:0] lo;
    hi = CORR_W'(lim);
    lo = -hi;
    priority if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end else begin
      return x;
    end
  endfunction

  function automatic logic signed [Q15_W-1:0] sat16(input logic signed [MIX_W-1:0] x);
    priority if (x > Q15_MAX) begin
      return Q15_MAX[Q15_W-1:0];
    end else if (x < Q15_MIN) begin
      return Q15_MIN[Q15_W-1:0];
    end else begin
      return x[Q15_W-1:0];
    end
  endfunction

  // configuration
  logic [GAIN_W-1:0]       turn_kp_q, turn_kd_q, drive_kp_q, drive_kd_q;
  logic signed [Q15_W-1:0] cruise_q;
  logic [TOL_W-1:0]        head_tol_q, dist_tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_kp_q  <= GAIN_RST;
      turn_kd_q  <= GAIN_RST;
      drive_kp_q <= GAIN_RST;
      drive_kd_q <= GAIN_RST;
      cruise_q   <= '0;
      head_tol_q <= HEAD_TOL_RST;
      dist_tol_q <= DIST_TOL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TURN_KP:      turn_kp_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_TURN_KD:      turn_kd_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_DRIVE_KP:     drive_kp_q <= cfg_data_i[GAIN_W-1:0];
        CFG_DRIVE_KD:     drive_kd_q <= cfg_data_i[GAIN_W-1:0];
        CFG_CRUISE_SPEED: cruise_q   <= cfg_data_i[Q15_W-1:0];
        CFG_HEAD_TOL:     head_tol_q <= cfg_data_i[TOL_W-1:0];
        CFG_DIST_TOL:     dist_tol_q <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q, out_vld_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy, out_rdy;
  logic in_acc;

  assign out_rdy    = !out_vld_q || !out_stall_i;
  assign s6_rdy     = !s6_vld_q || out_rdy;
  assign s5_rdy     = !s5_vld_q || s6_rdy;
  assign s4_rdy     = !s4_vld_q || s5_rdy;
  assign s3_rdy     = !s3_vld_q || s4_rdy;
  assign s2_rdy     = !s2_vld_q || s3_rdy;
  assign s1_rdy     = !s1_vld_q || s2_rdy;
  assign in_stall_o = !s1_rdy;
  assign in_acc     = in_valid_i && s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_vld_q  <= in_valid_i;
      if (s2_rdy)  s2_vld_q  <= s1_vld_q;
      if (s3_rdy)  s3_vld_q  <= s2_vld_q;
      if (s4_rdy)  s4_vld_q  <= s3_vld_q;
      if (s5_rdy)  s5_vld_q  <= s4_vld_q;
      if (s6_rdy)  s6_vld_q  <= s5_vld_q;
      if (out_rdy) out_vld_q <= s6_vld_q;
    end
  end

  // stage 1: errors and stored errors
  logic signed [HEW-1:0] he, last_he_q;
  logic signed [HDW-1:0] hd;
  logic signed [DEW-1:0] de, last_de_q;
  logic signed [DDW-1:0] dd;

  assign he = HEW'(target_heading_i) - HEW'(measured_heading_i);
  assign hd = HDW'(he) - HDW'(last_he_q);
  assign de = DEW'(target_distance_i) - DEW'(measured_distance_i);
  assign dd = DDW'(de) - DDW'(last_de_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_he_q <= '0;
      last_de_q <= '0;
    end else if (in_acc) begin
      unique case (req_type_i)
        REQ_TURN, REQ_HEAD_DRIVE, REQ_HEAD_LIM: last_he_q <= he;
        REQ_DIST: last_de_q <= de;
        REQ_DIST_HEAD: begin
          last_he_q <= he;
          last_de_q <= de;
        end
        REQ_CLEAR: begin
          last_he_q <= '0;
          last_de_q <= '0;
        end
        default: ;
      endcase
    end
  end

  logic [2:0]              s1_req_q;
  logic signed [HEW-1:0]   s1_he_q;
  logic signed [HDW-1:0]   s1_hd_q;
  logic signed [DEW-1:0]   s1_de_q;
  logic signed [DDW-1:0]   s1_dd_q;
  logic signed [Q15_W-1:0] s1_spd_q;
  logic [MAXT_W-1:0]       s1_mt_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q <= req_type_i;
      s1_he_q  <= he;
      s1_hd_q  <= hd;
      s1_de_q  <= de;
      s1_dd_q  <= dd;
      s1_spd_q <= speed_i;
      s1_mt_q  <= max_turn_i;
    end
  end

  // stage 2: magnitudes and signs
  logic [2:0]              s2_req_q;
  logic [HEW-1:0]          s2_hem_q;
  logic [HDW-1:0]          s2_hdm_q;
  logic [DEW-1:0]          s2_dem_q;
  logic [DDW-1:0]          s2_ddm_q;
  logic                    s2_hen_q, s2_hdn_q, s2_den_q, s2_ddn_q;
  logic signed [Q15_W-1:0] s2_spd_q;
  logic [MAXT_W-1:0]       s2_mt_q;

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_vld_q) begin
      s2_req_q <= s1_req_q;
      s2_hem_q <= s1_he_q[HEW-1] ? HEW'(-s1_he_q) : HEW'(s1_he_q);
      s2_hdm_q <= s1_hd_q[HDW-1] ? HDW'(-s1_hd_q) : HDW'(s1_hd_q);
      s2_dem_q <= s1_de_q[DEW-1] ? DEW'(-s1_de_q) : DEW'(s1_de_q);
      s2_ddm_q <= s1_dd_q[DDW-1] ? DDW'(-s1_dd_q) : DDW'(s1_dd_q);
      s2_hen_q <= s1_he_q[HEW-1];
      s2_hdn_q <= s1_hd_q[HDW-1];
      s2_den_q <= s1_de_q[DEW-1];
      s2_ddn_q <= s1_dd_q[DDW-1];
      s2_spd_q <= s1_spd_q;
      s2_mt_q  <= s1_mt_q;
    end
  end

  // stage 3: products and done tests
  logic [2:0]              s3_req_q;
  logic [HEPW-1:0]         s3_hep_q;
  logic [HDPW-1:0]         s3_hdp_q;
  logic [DEPW-1:0]         s3_dep_q;
  logic [DDPW-1:0]         s3_ddp_q;
  logic                    s3_hen_q, s3_hdn_q, s3_den_q, s3_ddn_q;
  logic                    s3_hdone_q, s3_ddone_q, s3_dclose_q;
  logic signed [Q15_W-1:0] s3_spd_q;
  logic [MAXT_W-1:0]       s3_mt_q;
  logic                    dclose;

  assign dclose = s2_dem_q < DEW'(DIST_TOL);

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_vld_q) begin
      s3_req_q    <= s2_req_q;
      s3_hep_q    <= HEPW'(s2_hem_q) * HEPW'(turn_kp_q);
      s3_hdp_q    <= HDPW'(s2_hdm_q) * HDPW'(turn_kd_q);
      s3_dep_q    <= DEPW'(s2_dem_q) * DEPW'(drive_kp_q);
      s3_ddp_q    <= DDPW'(s2_ddm_q) * DDPW'(drive_kd_q);
      s3_hen_q    <= s2_hen_q;
      s3_hdn_q    <= s2_hdn_q;
      s3_den_q    <= s2_den_q;
      s3_ddn_q    <= s2_ddn_q;
      s3_hdone_q  <= (s2_hem_q < HEW'(HEAD_TOL)) && (HTCW'(s2_hdm_q) < HTCW'(head_tol_q));
      s3_ddone_q  <= dclose && (DTCW'(s2_ddm_q) < DTCW'(dist_tol_q));
      s3_dclose_q <= dclose;
      s3_spd_q    <= s2_spd_q;
      s3_mt_q     <= s2_mt_q;
    end
  end

  // stage 4: saturate products and apply sign
  logic [2:0]               s4_req_q;
  logic signed [TERM_W-1:0] s4_hp_q, s4_hd_q, s4_dp_q, s4_dd_q;
  logic                     s4_hdone_q, s4_ddone_q, s4_dclose_q;
  logic signed [Q15_W-1:0]  s4_spd_q;
  logic [MAXT_W-1:0]        s4_mt_q;

  always_ff @(posedge clk_i) begin
    if (s4_rdy && s3_vld_q) begin
      s4_req_q    <= s3_req_q;
      s4_hp_q     <= sign_sat(PROD_EXT_W'(s3_hep_q), s3_hen_q);
      s4_hd_q     <= sign_sat(PROD_EXT_W'(s3_hdp_q), s3_hdn_q);
      s4_dp_q     <= sign_sat(PROD_EXT_W'(s3_dep_q), s3_den_q);
      s4_dd_q     <= sign_sat(PROD_EXT_W'(s3_ddp_q), s3_ddn_q);
      s4_hdone_q  <= s3_hdone_q;
      s4_ddone_q  <= s3_ddone_q;
      s4_dclose_q <= s3_dclose_q;
      s4_spd_q    <= s3_spd_q;
      s4_mt_q     <= s3_mt_q;
    end
  end

  // stage 5: PD sum, round to nearest
  logic signed [SUM_W-1:0]  hsum, dsum;
  logic [2:0]               s5_req_q;
  logic signed [CORR_W-1:0] s5_ch_q, s5_cd_q;
  logic                     s5_hdone_q, s5_ddone_q, s5_dclose_q;
  logic signed [Q15_W-1:0]  s5_spd_q;
  logic [MAXT_W-1:0]        s5_mt_q;

  assign hsum = SUM_W'(s4_hp_q) + SUM_W'(s4_hd_q) + RND_HALF;
  assign dsum = SUM_W'(s4_dp_q) + SUM_W'(s4_dd_q) + RND_HALF;

  always_ff @(posedge clk_i) begin
    if (s5_rdy && s4_vld_q) begin
      s5_req_q    <= s4_req_q;
      s5_ch_q     <= hsum[SUM_W-1:RND_SHIFT];
      s5_cd_q     <= dsum[SUM_W-1:RND_SHIFT];
      s5_hdone_q  <= s4_hdone_q;
      s5_ddone_q  <= s4_ddone_q;
      s5_dclose_q <= s4_dclose_q;
      s5_spd_q    <= s4_spd_q;
      s5_mt_q     <= s4_mt_q;
    end
  end

  // stage 6: mode select, limits
  logic signed [BASE_W-1:0] base_d, s6_base_q;
  logic signed [CORR_W-1:0] corr_d, s6_corr_q;
  logic                     done_d, s6_done_q;
  logic signed [LIM_W-1:0]  spd_lim, mt_lim;

  assign spd_lim = LIM_W'(s5_spd_q);
  assign mt_lim  = LIM_W'(s5_mt_q);

  always_comb begin
    base_d = '0;
    corr_d = '0;
    done_d = 1'b0;
    unique case (s5_req_q)
      REQ_TURN: begin
        corr_d = s5_ch_q;
        done_d = s5_hdone_q;
      end
      REQ_HEAD_DRIVE: begin
        base_d = BASE_W'(s5_spd_q);
        corr_d = s5_ch_q;
        done_d = s5_hdone_q;
      end
      REQ_HEAD_LIM: begin
        base_d = BASE_W'(s5_spd_q);
        corr_d = clamp(s5_ch_q, mt_lim);
        done_d = s5_hdone_q;
      end
      REQ_DIST: begin
        base_d = BASE_W'(cruise_q);
        corr_d = s5_cd_q;
        done_d = s5_ddone_q;
      end
      REQ_DIST_HEAD: begin
        base_d = BASE_W'(-clamp(s5_cd_q, spd_lim));
        corr_d = s5_ch_q;
        done_d = s5_dclose_q && s5_hdone_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s6_rdy && s5_vld_q) begin
      s6_base_q <= base_d;
      s6_corr_q <= corr_d;
      s6_done_q <= done_d;
    end
  end

  // stage 7: drive mix and saturation
  logic signed [Q15_W-1:0] left_q, right_q;
  logic                    done_q;

  always_ff @(posedge clk_i) begin
    if (out_rdy && s6_vld_q) begin
      left_q  <= sat16(MIX_W'(s6_base_q) - MIX_W'(s6_corr_q));
      right_q <= sat16(MIX_W'(s6_base_q) + MIX_W'(s6_corr_q));
      done_q  <= s6_done_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign done_res_o    = done_q;

endmodule
